// ===== sv/fsc_pkg.sv =====
package fsc_pkg;

  localparam int SAMPLE_POINTS = 80;
  localparam int HALF = SAMPLE_POINTS / 2;
  localparam int GRADE_W = 17;
  localparam int DIST_W = 17;
  localparam logic [GRADE_W-1:0] GRADE_ONE = 17'h10000;
  localparam logic [DIST_W-1:0] SPAN_RESET = 17'd5000;
  localparam int GROUP = 8;
  localparam int NGROUP = (SAMPLE_POINTS + GROUP - 1) / GROUP;
  localparam int SUM_W = $clog2(SAMPLE_POINTS) + GRADE_W;
  localparam int Q_W = $clog2(HALF + 1);
  localparam int MAG_W = SUM_W + Q_W;
  localparam int WSUM_W = MAG_W + 1;
  localparam int WT_W = Q_W + 1;
  localparam int DIV_STEPS = 16;

  typedef struct packed {
    logic [DIST_W-1:0] left_distance;
    logic [DIST_W-1:0] middle_distance;
    logic [DIST_W-1:0] right_distance;
  } in_item_t;

  typedef struct packed {
    logic signed [6:0] steering;
    logic              no_rule_fired;
  } out_item_t;

  function automatic logic [GRADE_W-1:0] shape_pt(int num);
    return GRADE_W'((longint'(num) * 65536) / HALF);
  endfunction

  function automatic logic [GRADE_W-1:0] min2(logic [GRADE_W-1:0] a, logic [GRADE_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

// ===== sv/fuzzy_steering_controller.sv =====
// result path: grade divs, rules, clip, sums, totals, sign, centroid div, output
// throughput: one transaction per cycle; busy is always low
// latency set by the 16-step grade divider and the centroid divider pipelines
// reset: synchronous active-low rst_n clears all valid bits, span returns to 5000
// the receiver cannot stall: each result is shown for one cycle only
module fuzzy_steering_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  fsc_pkg::in_item_t  in_data,
  output logic               out_valid,
  output fsc_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import fsc_pkg::*;

  logic [DIST_W-1:0] span_r;
  logic              acc;
  logic              gv0, gv1, gv2;
  logic [GRADE_W-1:0] lb, mb, rb;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign prdata = {15'b0, span_r};
  assign acc    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r <= SPAN_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      span_r <= pwdata[DIST_W-1:0];
    end
  end

  fsc_grade u_gl (.clk, .rst_n, .vld_in(acc), .distance(in_data.left_distance),
                  .span(span_r), .vld_out(gv0), .grade(lb));
  fsc_grade u_gm (.clk, .rst_n, .vld_in(acc), .distance(in_data.middle_distance),
                  .span(span_r), .vld_out(gv1), .grade(mb));
  fsc_grade u_gr (.clk, .rst_n, .vld_in(acc), .distance(in_data.right_distance),
                  .span(span_r), .vld_out(gv2), .grade(rb));

  // rule strengths
  logic               rv_r;
  logic [GRADE_W-1:0] r1_r, r2_r, r3_r;
  logic [GRADE_W-1:0] ls, rs;
  assign ls = GRADE_ONE - lb;
  assign rs = GRADE_ONE - rb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
    end else begin
      rv_r <= gv0 && gv1 && gv2;
    end
    r1_r <= min2(lb, rs);
    r2_r <= min2(ls, rb);
    r3_r <= min2(min2(ls, mb), rs);
  end

  // clipped and combined output set
  logic               cv_r;
  logic [GRADE_W-1:0] c_r [0:SAMPLE_POINTS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= 1'b0;
    end else begin
      cv_r <= rv_r;
    end
  end

  for (genvar i = 0; i < SAMPLE_POINTS; i++) begin : g_pt
    localparam logic [GRADE_W-1:0] SA = (i < HALF) ? shape_pt(HALF - i) : shape_pt(i - HALF);
    localparam logic [GRADE_W-1:0] SB = (i < HALF) ? shape_pt(i) : shape_pt(SAMPLE_POINTS - i);
    logic [GRADE_W-1:0] a, b;
    always_comb begin
      a = min2((i < HALF) ? r1_r : r2_r, SA);
      b = min2(r3_r, SB);
    end
    always_ff @(posedge clk) begin
      c_r[i] <= (b > a) ? b : a;
    end
  end

  // group partial sums
  logic                     pv_r;
  logic [SUM_W-1:0]         ps_r [0:NGROUP-1];
  logic signed [WSUM_W-1:0] pw_r [0:NGROUP-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= cv_r;
    end
  end

  for (genvar g = 0; g < NGROUP; g++) begin : g_grp
    logic [SUM_W-1:0]         s;
    logic signed [WSUM_W-1:0] w;
    always_comb begin
      s = '0;
      w = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < SAMPLE_POINTS) begin
          s = s + SUM_W'(c_r[g * GROUP + k]);
          w = w + WSUM_W'($signed({1'b0, c_r[g * GROUP + k]}) *
                          $signed(WT_W'(g * GROUP + k - HALF)));
        end
      end
    end
    always_ff @(posedge clk) begin
      ps_r[g] <= s;
      pw_r[g] <= w;
    end
  end

  // totals
  logic                     tv_r;
  logic [SUM_W-1:0]         ts_r;
  logic signed [WSUM_W-1:0] tw_r;
  logic [SUM_W-1:0]         ts_nxt;
  logic signed [WSUM_W-1:0] tw_nxt;

  always_comb begin
    ts_nxt = '0;
    tw_nxt = '0;
    for (int g = 0; g < NGROUP; g++) begin
      ts_nxt = ts_nxt + ps_r[g];
      tw_nxt = tw_nxt + pw_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= 1'b0;
    end else begin
      tv_r <= pv_r;
    end
    ts_r <= ts_nxt;
    tw_r <= tw_nxt;
  end

  // sign and magnitude
  logic             mv_r, mn_r, mf_r;
  logic [MAG_W-1:0] mm_r;
  logic [SUM_W-1:0] md_r;
  logic [WSUM_W-1:0] tneg;
  assign tneg = -tw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else begin
      mv_r <= tv_r;
    end
    mn_r <= tw_r[WSUM_W-1];
    mm_r <= tw_r[WSUM_W-1] ? tneg[MAG_W-1:0] : tw_r[MAG_W-1:0];
    md_r <= ts_r;
    mf_r <= (ts_r == '0);
  end

  logic           dv, dn, df;
  logic [Q_W-1:0] dq;

  fsc_cdiv u_div (.clk, .rst_n, .vld_in(mv_r), .mag(mm_r), .den(md_r),
                  .neg_in(mn_r), .nf_in(mf_r), .vld_out(dv), .quo(dq),
                  .neg_out(dn), .nf_out(df));

  // saturate and register result
  logic              ov_r;
  out_item_t         od_r;
  logic [8:0]        qx;
  logic signed [6:0] st;

  always_comb begin
    qx = 9'(dq);
    if (df) begin
      st = '0;
    end else if (dn) begin
      st = (qx > 9'd64) ? -7'sd64 : 7'(-qx);
    end else begin
      st = (qx > 9'd63) ? 7'sd63 : 7'(qx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= dv;
    end
    od_r.steering      <= st;
    od_r.no_rule_fired <= df;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

// ===== sv/fsc_grade.sv =====
module fsc_grade (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       vld_in,
  input  logic [fsc_pkg::DIST_W-1:0] distance,
  input  logic [fsc_pkg::DIST_W-1:0] span,
  output logic                       vld_out,
  output logic [fsc_pkg::GRADE_W-1:0] grade
);
  import fsc_pkg::*;

  logic              v_r   [0:DIV_STEPS];
  logic              z_r   [0:DIV_STEPS];
  logic              s_r   [0:DIV_STEPS];
  logic [DIST_W-1:0] rem_r [0:DIV_STEPS];
  logic [15:0]       q_r   [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= vld_in;
    end
    z_r[0]   <= (distance == '0);
    s_r[0]   <= (distance >= span);
    rem_r[0] <= distance;
    q_r[0]   <= '0;
  end

  for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
    logic [DIST_W:0]   rem2;
    logic              ge;
    logic [DIST_W-1:0] rem_nxt;
    always_comb begin
      rem2    = {rem_r[s-1], 1'b0};
      ge      = rem2 >= {1'b0, span};
      rem_nxt = ge ? DIST_W'(rem2 - {1'b0, span}) : DIST_W'(rem2);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= v_r[s-1];
      end
      z_r[s]   <= z_r[s-1];
      s_r[s]   <= s_r[s-1];
      rem_r[s] <= rem_nxt;
      q_r[s]   <= {q_r[s-1][14:0], ge};
    end
  end

  assign vld_out = v_r[DIV_STEPS];
  assign grade = z_r[DIV_STEPS] ? '0 :
                 s_r[DIV_STEPS] ? GRADE_ONE : {1'b0, q_r[DIV_STEPS]};

endmodule

// ===== sv/fsc_cdiv.sv =====
module fsc_cdiv (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      vld_in,
  input  logic [fsc_pkg::MAG_W-1:0] mag,
  input  logic [fsc_pkg::SUM_W-1:0] den,
  input  logic                      neg_in,
  input  logic                      nf_in,
  output logic                      vld_out,
  output logic [fsc_pkg::Q_W-1:0]   quo,
  output logic                      neg_out,
  output logic                      nf_out
);
  import fsc_pkg::*;

  logic             v_r   [0:Q_W];
  logic             n_r   [0:Q_W];
  logic             f_r   [0:Q_W];
  logic [MAG_W-1:0] rem_r [0:Q_W];
  logic [SUM_W-1:0] den_r [0:Q_W];
  logic [Q_W-1:0]   q_r   [0:Q_W];

  always_comb begin
    v_r[0]   = vld_in;
    n_r[0]   = neg_in;
    f_r[0]   = nf_in;
    rem_r[0] = mag;
    den_r[0] = den;
    q_r[0]   = '0;
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_step
    logic [MAG_W-1:0] dsh;
    logic             ge;
    always_comb begin
      dsh = MAG_W'(den_r[j]) << (Q_W - 1 - j);
      ge  = rem_r[j] >= dsh;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else begin
        v_r[j+1] <= v_r[j];
      end
      n_r[j+1]   <= n_r[j];
      f_r[j+1]   <= f_r[j];
      den_r[j+1] <= den_r[j];
      rem_r[j+1] <= ge ? rem_r[j] - dsh : rem_r[j];
      q_r[j+1]   <= ge ? (q_r[j] | (Q_W'(1) << (Q_W - 1 - j))) : q_r[j];
    end
  end

  assign vld_out = v_r[Q_W];
  assign quo     = q_r[Q_W];
  assign neg_out = n_r[Q_W];
  assign nf_out  = f_r[Q_W];

endmodule
